/* design/rocs_pkg.sv */
// Shared types, codes and reset values of the rotor offset calibration sequencer.
`timescale 1ns / 1ps

package rocs_pkg;

   // Phase codes of the calibration sequence.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TEST = 2'd1;
   localparam logic [1:0] PH_CALC = 2'd2;
   localparam logic [1:0] PH_SAVE = 2'd3;

   // Current reference selections.
   localparam logic [1:0] CREF_KEEP  = 2'd0;
   localparam logic [1:0] CREF_ALIGN = 2'd1;
   localparam logic [1:0] CREF_RUN   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_ANGLE_OFFSET     = 2'd0;
   localparam logic [1:0] CSR_SPREAD_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_ZERO_SPEED_TICKS = 2'd2;
   localparam logic [1:0] CSR_MAX_ALIGN_TICKS  = 2'd3;

   // Register reset values.
   localparam logic [8:0]  RST_ANGLE_OFFSET     = 9'd330;
   localparam logic [8:0]  RST_SPREAD_LIMIT     = 9'd12;
   localparam logic [15:0] RST_ZERO_SPEED_TICKS = 16'd300;
   localparam logic [15:0] RST_MAX_ALIGN_TICKS  = 16'd3000;

   // One full electrical turn in degrees.
   localparam logic [9:0] ANGLE_TURN = 10'd360;

   // Input word: one control tick.
   typedef struct packed {
      logic        fault_active;
      logic        run_request;
      logic        speed_is_zero;
      logic        capture_done;
      logic [15:0] angle_first;
      logic [15:0] angle_second;
      logic [15:0] angle_third;
   } rocs_req_type;

   // Result word: sequencer outputs after the tick.
   typedef struct packed {
      logic [1:0] phase;
      logic       motor_run;
      logic       dc_align_active;
      logic [1:0] current_ref_select;
      logic       clear_controllers;
      logic       encoder_reset;
      logic       reload_mode_params;
      logic [8:0] offset_angle;
      logic       offset_valid;
      logic       test_complete;
      logic       spread_reject;
   } rocs_rsp_type;

   // Verdict of the angle calculation.
   typedef struct packed {
      logic       reject;
      logic [8:0] offset;
   } rocs_calc_type;

endpackage

/* design/rotor_offset_calibration_sequencer_unit.sv */
// Top level of the rotor offset calibration sequencer.
`timescale 1ns / 1ps

// Each accepted word is one control tick: the sequencer steps through idle,
// DC alignment and test, calculate and save, and returns one result word
// per tick. A tick is taken in every cycle while req_stall is low. The step logic
// and the angle calculation are combinational; their result is set by the single
// register stage behind them. A two-word output buffer lets a tick be taken
// while an earlier result still waits; req_stall rises only when both words
// are held. Configuration writes take effect at the next tick.
module rotor_offset_calibration_sequencer_unit
   import rocs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rocs_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rocs_rsp_type rsp_word,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   // Configuration registers.
   logic [8:0]  angle_offset_ff;
   logic [8:0]  spread_limit_ff;
   logic [15:0] zero_speed_ticks_ff;
   logic [15:0] max_align_ticks_ff;

   // Sequencer state.
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] standstill_ff, standstill_in;
   logic [15:0] align_cnt_ff, align_cnt_in;
   logic        interlock_ff, interlock_in;
   logic        align_done_ff, align_done_in;
   logic        motor_ff, motor_in;
   logic        tested_ff, tested_in;
   logic [8:0]  offset_ff, offset_in;
   logic        dc_ff, dc_in;

   // Output buffer.
   logic         out_valid_ff;
   rocs_rsp_type out_word_ff;
   logic         skid_valid_ff;
   rocs_rsp_type skid_word_ff;

   logic          accept;
   logic          take;
   rocs_calc_type calc;
   rocs_rsp_type  step_word;
   logic [1:0]    cref;
   logic          clr, enc, reload, valid, reject;
   logic [15:0]   standstill_inc;
   logic [15:0]   align_inc;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   rocs_angle_calc u_calc (
      .angle_first  (req_word.angle_first),
      .angle_second (req_word.angle_second),
      .angle_third  (req_word.angle_third),
      .spread_limit (spread_limit_ff),
      .angle_offset (angle_offset_ff),
      .calc         (calc)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_offset_ff     <= RST_ANGLE_OFFSET;
         spread_limit_ff     <= RST_SPREAD_LIMIT;
         zero_speed_ticks_ff <= RST_ZERO_SPEED_TICKS;
         max_align_ticks_ff  <= RST_MAX_ALIGN_TICKS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANGLE_OFFSET:     angle_offset_ff     <= csr_data[8:0];
            CSR_SPREAD_LIMIT:     spread_limit_ff     <= csr_data[8:0];
            CSR_ZERO_SPEED_TICKS: zero_speed_ticks_ff <= csr_data;
            CSR_MAX_ALIGN_TICKS:  max_align_ticks_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign standstill_inc = standstill_ff + 16'd1;
   assign align_inc      = align_cnt_ff + 16'd1;

   // One tick of the sequence.
   always_comb begin
      phase_in      = phase_ff;
      standstill_in = standstill_ff;
      align_cnt_in  = align_cnt_ff;
      interlock_in  = interlock_ff;
      align_done_in = align_done_ff;
      motor_in      = motor_ff;
      tested_in     = tested_ff;
      offset_in     = offset_ff;
      dc_in         = dc_ff;
      cref          = CREF_KEEP;
      clr           = 1'b0;
      enc           = 1'b0;
      reload        = 1'b0;
      valid         = 1'b0;
      reject        = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (!req_word.fault_active && req_word.run_request && !interlock_ff) begin
               phase_in      = PH_TEST;
               tested_in     = 1'b0;
               align_done_in = 1'b0;
               clr           = 1'b1;
            end else begin
               motor_in = 1'b0;
               dc_in    = 1'b0;
               reload   = 1'b1;
               if (!req_word.run_request) begin
                  interlock_in = 1'b0;
               end
            end
         end
         PH_TEST: begin
            if (req_word.capture_done) begin
               motor_in = 1'b0;
               phase_in = PH_CALC;
            end else if (!align_done_ff) begin
               dc_in         = 1'b1;
               motor_in      = 1'b1;
               cref          = CREF_ALIGN;
               align_cnt_in  = align_inc;
               standstill_in = req_word.speed_is_zero ? standstill_inc : 16'd0;
               if ((standstill_in > zero_speed_ticks_ff) ||
                   (align_inc > max_align_ticks_ff)) begin
                  dc_in         = 1'b0;
                  standstill_in = 16'd0;
                  align_cnt_in  = 16'd0;
                  enc           = 1'b1;
                  align_done_in = 1'b1;
               end
            end else begin
               cref = CREF_RUN;
            end
         end
         PH_CALC: begin
            if (calc.reject) begin
               phase_in     = PH_IDLE;
               interlock_in = 1'b1;
               reject       = 1'b1;
            end else begin
               offset_in = calc.offset;
               phase_in  = PH_SAVE;
               valid     = 1'b1;
            end
         end
         default: begin
            tested_in    = 1'b1;
            phase_in     = PH_IDLE;
            interlock_in = 1'b1;
         end
      endcase
   end

   // Result word of this tick.
   always_comb begin
      step_word.phase              = phase_in;
      step_word.motor_run          = motor_in;
      step_word.dc_align_active    = dc_in;
      step_word.current_ref_select = cref;
      step_word.clear_controllers  = clr;
      step_word.encoder_reset      = enc;
      step_word.reload_mode_params = reload;
      step_word.offset_angle       = offset_in;
      step_word.offset_valid       = valid;
      step_word.test_complete      = tested_in;
      step_word.spread_reject      = reject;
   end

   // State update on every accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         standstill_ff <= 16'd0;
         align_cnt_ff  <= 16'd0;
         interlock_ff  <= 1'b1;
         align_done_ff <= 1'b0;
         motor_ff      <= 1'b0;
         tested_ff     <= 1'b0;
         offset_ff     <= 9'd0;
         dc_ff         <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         standstill_ff <= standstill_in;
         align_cnt_ff  <= align_cnt_in;
         interlock_ff  <= interlock_in;
         align_done_ff <= align_done_in;
         motor_ff      <= motor_in;
         tested_ff     <= tested_in;
         offset_ff     <= offset_in;
         dc_ff         <= dc_in;
      end
   end

   // Output register with a skid word behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            out_word_ff   <= skid_word_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            out_word_ff <= step_word;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_word_ff  <= step_word;
            out_valid_ff <= 1'b1;
         end else begin
            skid_word_ff  <= step_word;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // The skid word is only ever filled behind a waiting output word.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // A published offset only comes with the save phase.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.offset_valid) |-> (rsp_word.phase == PH_SAVE))
      else $error("offset published outside save phase");

   // Alignment end drops the DC pattern and still reports the alignment current.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.encoder_reset) |->
         (!rsp_word.dc_align_active && rsp_word.current_ref_select == CREF_ALIGN))
      else $error("encoder reset without alignment end");

   // A full buffer holds its state until the output word is taken.
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(phase_ff)))
      else $error("sequencer advanced while the buffer was full");

endmodule

/* design/rocs_angle_calc.sv */
// Angle reduction, averaging, spread check and offset addition.
`timescale 1ns / 1ps

module rocs_angle_calc
   import rocs_pkg::*;
(
   input  logic [15:0]   angle_first,
   input  logic [15:0]   angle_second,
   input  logic [15:0]   angle_third,
   input  logic [8:0]    spread_limit,
   input  logic [8:0]    angle_offset,
   output rocs_calc_type calc
);

   // Reduce a 16-bit angle to one turn: reciprocal estimate, then one correction.
   function automatic logic [8:0] reduce_angle(input logic [15:0] a);
      logic [23:0] prod;
      logic [16:0] base;
      logic [9:0]  rem;
      prod = {8'd0, a} * 24'd182;
      base = {9'd0, prod[23:16]} * {7'd0, ANGLE_TURN};
      rem  = 10'({1'b0, a} - base);
      if (rem >= ANGLE_TURN) begin
         reduce_angle = 9'(rem - ANGLE_TURN);
      end else begin
         reduce_angle = rem[8:0];
      end
   endfunction

   // Absolute distance of two reduced angles.
   function automatic logic [8:0] angle_dist(input logic [8:0] a, input logic [8:0] b);
      angle_dist = (a > b) ? (a - b) : (b - a);
   endfunction

   logic [8:0]  red_first;
   logic [8:0]  red_second;
   logic [8:0]  red_third;
   logic [10:0] angle_sum;
   logic [20:0] avg_prod;
   logic [8:0]  avg;
   logic [9:0]  sum_raw;
   logic [9:0]  sum_once;
   logic [9:0]  sum_twice;

   assign red_first  = reduce_angle(angle_first);
   assign red_second = reduce_angle(angle_second);
   assign red_third  = reduce_angle(angle_third);

   // Average of three: multiply by 683/2048, exact for sums below 1080.
   assign angle_sum = {2'd0, red_first} + {2'd0, red_second} + {2'd0, red_third};
   assign avg_prod  = {10'd0, angle_sum} * 21'd683;
   assign avg       = avg_prod[19:11];

   // Any capture too far from the average rejects the result.
   assign calc.reject = (angle_dist(avg, red_first) > spread_limit) ||
                        (angle_dist(avg, red_second) > spread_limit) ||
                        (angle_dist(avg, red_third) > spread_limit);

   // The sum stays below three turns, so two corrections finish the reduction.
   assign sum_raw   = {1'b0, avg} + {1'b0, angle_offset};
   assign sum_once  = (sum_raw >= ANGLE_TURN) ? (sum_raw - ANGLE_TURN) : sum_raw;
   assign sum_twice = (sum_once >= ANGLE_TURN) ? (sum_once - ANGLE_TURN) : sum_once;
   assign calc.offset = sum_twice[8:0];

endmodule

/* dv/rocs_tick_checker.sv */
// Checker that predicts and compares the result words of the calibration sequencer.
`timescale 1ns / 1ps

module rocs_tick_checker
   import rocs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  rocs_req_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rocs_rsp_type rsp_word,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int unsigned  mismatches,
   output int unsigned  results_due
);

   // Register copies as the block should hold them.
   logic [8:0]  offset_cfg;
   logic [8:0]  spread_cfg;
   logic [15:0] still_limit;
   logic [15:0] align_limit;

   // Sequencer state as the block should hold it.
   logic [1:0]  phase_now;
   logic [15:0] standstill_cnt;
   logic [15:0] align_cnt;
   logic        interlock;
   logic        align_done;
   logic        running;
   logic        tested;
   logic [8:0]  offset_held;
   logic        dc_pattern;

   // Result words predicted for ticks whose results have not come yet.
   rocs_rsp_type pending_results[$];
   rocs_rsp_type want;
   rocs_rsp_type predicted;

   // Distance between two reduced angles.
   function automatic int unsigned angle_gap(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // One control tick of the sequencer; updates the state and builds the result word.
   task automatic advance_sequencer(input rocs_req_type t, output rocs_rsp_type r);
      int unsigned a1;
      int unsigned a2;
      int unsigned a3;
      int unsigned mean;
      int unsigned spread_wide;
      logic [1:0]  cref;
      logic        clr;
      logic        enc;
      logic        reload;
      logic        accepted;
      logic        reject;
      a1 = 32'(t.angle_first) % 32'(ANGLE_TURN);
      a2 = 32'(t.angle_second) % 32'(ANGLE_TURN);
      a3 = 32'(t.angle_third) % 32'(ANGLE_TURN);
      spread_wide = 32'(spread_cfg);
      cref = CREF_KEEP;
      clr = 1'b0;
      enc = 1'b0;
      reload = 1'b0;
      accepted = 1'b0;
      reject = 1'b0;
      case (phase_now)
         PH_IDLE: begin
            if (!t.fault_active && t.run_request && !interlock) begin
               phase_now = PH_TEST;
               tested = 1'b0;
               align_done = 1'b0;
               clr = 1'b1;
            end else begin
               running = 1'b0;
               dc_pattern = 1'b0;
               reload = 1'b1;
               if (!t.run_request) begin
                  interlock = 1'b0;
               end
            end
         end
         PH_TEST: begin
            // A capture ends the test at once, even during alignment.
            if (t.capture_done) begin
               running = 1'b0;
               phase_now = PH_CALC;
            end else if (!align_done) begin
               dc_pattern = 1'b1;
               running = 1'b1;
               cref = CREF_ALIGN;
               align_cnt = align_cnt + 16'd1;
               standstill_cnt = t.speed_is_zero ? standstill_cnt + 16'd1 : 16'd0;
               if (standstill_cnt > still_limit || align_cnt > align_limit) begin
                  dc_pattern = 1'b0;
                  standstill_cnt = 16'd0;
                  align_cnt = 16'd0;
                  enc = 1'b1;
                  align_done = 1'b1;
               end
            end else begin
               cref = CREF_RUN;
            end
         end
         PH_CALC: begin
            mean = (a1 + a2 + a3) / 3;
            if (angle_gap(mean, a1) > spread_wide || angle_gap(mean, a2) > spread_wide ||
                angle_gap(mean, a3) > spread_wide) begin
               phase_now = PH_IDLE;
               interlock = 1'b1;
               reject = 1'b1;
            end else begin
               offset_held = 9'((mean + 32'(offset_cfg)) % 32'(ANGLE_TURN));
               phase_now = PH_SAVE;
               accepted = 1'b1;
            end
         end
         default: begin
            tested = 1'b1;
            phase_now = PH_IDLE;
            interlock = 1'b1;
         end
      endcase
      r.phase = phase_now;
      r.motor_run = running;
      r.dc_align_active = dc_pattern;
      r.current_ref_select = cref;
      r.clear_controllers = clr;
      r.encoder_reset = enc;
      r.reload_mode_params = reload;
      r.offset_angle = offset_held;
      r.offset_valid = accepted;
      r.test_complete = tested;
      r.spread_reject = reject;
   endtask

   // Compare one field of a result word.
   task automatic check_field(input string name, input int unsigned expected_value,
                              input int unsigned actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
         mismatches++;
      end
   endtask

   // Watch the channels at each rising edge; results leave before new ticks enter.
   always @(posedge clock) begin
      if (reset) begin
         offset_cfg = RST_ANGLE_OFFSET;
         spread_cfg = RST_SPREAD_LIMIT;
         still_limit = RST_ZERO_SPEED_TICKS;
         align_limit = RST_MAX_ALIGN_TICKS;
         phase_now = PH_IDLE;
         standstill_cnt = 16'd0;
         align_cnt = 16'd0;
         interlock = 1'b1;
         align_done = 1'b0;
         running = 1'b0;
         tested = 1'b0;
         offset_held = 9'd0;
         dc_pattern = 1'b0;
         mismatches = 0;
         pending_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ANGLE_OFFSET:     offset_cfg = csr_data[8:0];
               CSR_SPREAD_LIMIT:     spread_cfg = csr_data[8:0];
               CSR_ZERO_SPEED_TICKS: still_limit = csr_data;
               default:              align_limit = csr_data;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result word arrived with no tick awaiting it");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("phase", 32'(want.phase), 32'(rsp_word.phase));
               check_field("motor_run", 32'(want.motor_run), 32'(rsp_word.motor_run));
               check_field("dc_align_active", 32'(want.dc_align_active),
                           32'(rsp_word.dc_align_active));
               check_field("current_ref_select", 32'(want.current_ref_select),
                           32'(rsp_word.current_ref_select));
               check_field("clear_controllers", 32'(want.clear_controllers),
                           32'(rsp_word.clear_controllers));
               check_field("encoder_reset", 32'(want.encoder_reset),
                           32'(rsp_word.encoder_reset));
               check_field("reload_mode_params", 32'(want.reload_mode_params),
                           32'(rsp_word.reload_mode_params));
               check_field("offset_angle", 32'(want.offset_angle),
                           32'(rsp_word.offset_angle));
               check_field("offset_valid", 32'(want.offset_valid),
                           32'(rsp_word.offset_valid));
               check_field("test_complete", 32'(want.test_complete),
                           32'(rsp_word.test_complete));
               check_field("spread_reject", 32'(want.spread_reject),
                           32'(rsp_word.spread_reject));
            end
         end
         if (req_valid && !req_stall) begin
            advance_sequencer(req_word, predicted);
            pending_results.push_back(predicted);
         end
      end
      results_due = pending_results.size();
   end

endmodule

/* dv/rotor_offset_calibration_sequencer_unit_test.sv */
// Stimulus and verdict for the rotor offset calibration sequencer.
`timescale 1ns / 1ps

module rotor_offset_calibration_sequencer_unit_test;
   import rocs_pkg::*;

   localparam int unsigned TICK_TARGET = 650;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned LONG_HOLD = 30;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   rocs_req_type req_word;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rocs_rsp_type rsp_word;
   logic         csr_write;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;

   int unsigned  mismatches;
   int unsigned  results_due;
   logic         req_fire = 1'b0;
   int unsigned  quiet_cycles = 0;
   int unsigned  ticks_sent = 0;
   bit           idling_on = 1'b1;
   int unsigned  hold_orders = 0;
   int unsigned  hold_served = 0;
   int unsigned  stall_left = 0;
   logic [8:0]   spread_now = RST_SPREAD_LIMIT;

   always #2 clock = ~clock;

   rotor_offset_calibration_sequencer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rocs_tick_checker tick_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   // Note accepted input words, and stop the run if the channels go quiet too long.
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall && !reset;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: short random stalls, plus one long hold-off when ordered.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_orders) begin
         hold_served <= hold_orders;
         stall_left <= LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic rocs_req_type make_tick(input logic fault, input logic run,
                                              input logic still, input logic capt,
                                              input logic [15:0] a1, input logic [15:0] a2,
                                              input logic [15:0] a3);
      rocs_req_type t;
      t.fault_active = fault;
      t.run_request = run;
      t.speed_is_zero = still;
      t.capture_done = capt;
      t.angle_first = a1;
      t.angle_second = a2;
      t.angle_third = a3;
      return t;
   endfunction

   function automatic rocs_req_type random_tick();
      return make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
   endfunction

   // Offer one word and hold it until the block takes it.
   task automatic send_tick(input rocs_req_type t);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= t;
      @(negedge clock);
      while (!req_fire) @(negedge clock);
      ticks_sent++;
   endtask

   // Stop sending and wait until every predicted result word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
   endtask

   // Registers change only once the block has drained and no tick is in flight.
   task automatic load_settings(input logic [8:0] offset, input logic [8:0] spread,
                                input logic [15:0] still_ticks, input logic [15:0] align_ticks);
      wait_drained();
      write_reg(CSR_ANGLE_OFFSET, {7'd0, offset});
      write_reg(CSR_SPREAD_LIMIT, {7'd0, spread});
      write_reg(CSR_ZERO_SPEED_TICKS, still_ticks);
      write_reg(CSR_MAX_ALIGN_TICKS, align_ticks);
      csr_write <= 1'b0;
      spread_now = spread;
   endtask

   // One calibration attempt: unlock, start, align, capture, calculate, save.
   task automatic run_calibration();
      int unsigned base;
      int unsigned pick;
      int unsigned dev_max;
      int unsigned k;
      int unsigned turn;
      int unsigned reduced[3];
      logic [15:0] raw[3];
      turn = 32'(ANGLE_TURN);
      repeat ($urandom_range(1, 2)) begin
         send_tick(make_tick(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
      end
      // Now and then a fault blocks the start and the rest runs against idle.
      send_tick(make_tick($urandom_range(0, 7) == 0, 1'b1, 1'($urandom_range(0, 1)), 1'b0,
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535))));
      repeat ($urandom_range(0, 8)) begin
         send_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 4) != 0, 1'b0,
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535))));
      end
      send_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b1, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
      // Captured angles: mostly clustered near the spread limit, sometimes scattered.
      base = $urandom_range(0, 359);
      pick = $urandom_range(0, 3);
      dev_max = (32'(spread_now) < 30) ? 32'(spread_now) + 1 : 30;
      for (k = 0; k < 3; k++) begin
         if (pick == 0) begin
            reduced[k] = $urandom_range(0, 359);
         end else begin
            reduced[k] = (base + $urandom_range(0, dev_max)) % turn;
         end
         raw[k] = 16'(reduced[k] + turn * $urandom_range(0, (65535 - reduced[k]) / turn));
      end
      send_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          raw[0], raw[1], raw[2]));
      send_tick(random_tick());
   endtask

   initial begin
      int unsigned phase_no;
      int unsigned phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write = 1'b0;
      csr_index = CSR_ANGLE_OFFSET;
      csr_data = 16'd0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset settings: interlock, faults, stray captures.
      send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0));
      // Capture during alignment, then the largest raw angles.
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd100, 16'd359));

      // Offset above a full turn, zero spread, alignment ends on the first standstill.
      load_settings(9'd511, 9'd0, 16'd0, 16'hFFFF);
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd359, 16'd719, 16'd1079));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd1));

      // Random calibration runs over a series of register settings.
      for (phase_no = 0; ticks_sent < TICK_TARGET; phase_no++) begin
         case (phase_no)
            0: load_settings(9'd0, 9'd359, 16'd0, 16'd0);
            1: load_settings(9'd359, 9'd12, 16'd3, 16'd6);
            2: load_settings(9'd511, 9'd511, 16'hFFFF, 16'd4);
            3: load_settings(9'($urandom_range(0, 511)), 9'($urandom_range(0, 30)), 16'd2,
                             16'hFFFF);
            4: load_settings(9'($urandom_range(0, 359)), 9'd20, 16'hFFFF, 16'hFFFF);
            default: load_settings(9'($urandom_range(0, 511)), 9'($urandom_range(0, 40)),
                                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)));
         endcase
         // Hold the result side off while words keep coming, so the block backs up.
         if (phase_no == 1) begin
            hold_orders++;
         end
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < 95 && ticks_sent < TICK_TARGET) begin
            if (ticks_sent > TICK_TARGET - 100) begin
               idling_on = 1'b0;
            end
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 4)) send_tick(random_tick());
            end else begin
               run_calibration();
            end
         end
      end

      wait_drained();
      repeat (5) @(negedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
